// File: hdl/sorted_priority_insert_queue_unit_defines.svh
// ----------------------------------------------------------------------------
// Sorted priority insert queue - assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_INSERT_QUEUE_UNIT_DEFINES_SVH
`define SORTED_PRIORITY_INSERT_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication
`define SPIQ_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPIQ_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/spiq_pkg.sv
// ----------------------------------------------------------------------------
// spiq_pkg
// Types and constants shared by the sorted priority insert queue modules.
// ----------------------------------------------------------------------------
package spiq_pkg;

  localparam int DEPTH_DEF    = 32;
  localparam int ID_BITS_DEF  = 16;
  localparam int KEY_BITS_DEF = 16;

  localparam int ID_FIELD_W  = 16;
  localparam int KEY_FIELD_W = 16;
  localparam int POS_W       = 6;
  localparam int STATUS_W    = 3;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_LIST   = 1'b1
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_EVICTED  = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_ENTRY    = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef struct packed {
    logic insert;
    logic rotate;
  } dp_cmd_t;

  typedef struct packed {
    logic drop;
    logic evict;
    logic empty;
  } dp_stat_t;

  typedef struct packed {
    logic    valid;
    status_t status;
    logic    entry;
    logic    last;
  } ctl_out_t;

endpackage

// File: hdl/spiq_datapath.sv
// ----------------------------------------------------------------------------
// spiq_datapath
// Entry cells with parallel compare-and-shift insert and a head rotate used
// to stream the sorted list.
// ----------------------------------------------------------------------------
module spiq_datapath #(
  parameter int DEPTH    = spiq_pkg::DEPTH_DEF,
  parameter int ID_BITS  = spiq_pkg::ID_BITS_DEF,
  parameter int KEY_BITS = spiq_pkg::KEY_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  spiq_pkg::dp_cmd_t                   cmd,
  input  logic [spiq_pkg::ID_FIELD_W-1:0]     in_id,
  input  logic [spiq_pkg::KEY_FIELD_W-1:0]    in_key,
  output spiq_pkg::dp_stat_t                  stat,
  output logic [$clog2(DEPTH+1)-1:0]          fill,
  output logic [spiq_pkg::ID_FIELD_W-1:0]     head_id,
  output logic [spiq_pkg::KEY_FIELD_W-1:0]    head_key
);

  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int ID_W   = (ID_BITS < spiq_pkg::ID_FIELD_W) ? ID_BITS : spiq_pkg::ID_FIELD_W;
  localparam int KEY_W  = (KEY_BITS < spiq_pkg::KEY_FIELD_W) ? KEY_BITS : spiq_pkg::KEY_FIELD_W;

  logic [KEY_W-1:0] keys [DEPTH];
  logic [ID_W-1:0]  ids  [DEPTH];
  logic [KEY_W-1:0] new_key;
  logic [ID_W-1:0]  new_id;
  logic [DEPTH-1:0] ge;
  logic             full;
  logic             evict;

  assign new_key = KEY_W'(in_key);
  assign new_id  = ID_W'(in_id);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ge[i] = (FILL_W'(i) < fill) && (keys[i] >= new_key);
    end
  end

  assign full  = (fill == FILL_W'(DEPTH));
  assign evict = full && (new_key > keys[DEPTH-1]);

  assign stat.drop  = full && !evict;
  assign stat.evict = evict;
  assign stat.empty = (fill == '0);

  assign head_id  = spiq_pkg::ID_FIELD_W'(ids[0]);
  assign head_key = spiq_pkg::KEY_FIELD_W'(keys[0]);

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [KEY_W-1:0] ins_key;
    logic [ID_W-1:0]  ins_id;
    logic [KEY_W-1:0] rot_key;
    logic [ID_W-1:0]  rot_id;

    if (g == 0) begin : g_first
      assign ins_key = new_key;
      assign ins_id  = new_id;
    end else begin : g_rest
      assign ins_key = ge[g-1] ? new_key : keys[g-1];
      assign ins_id  = ge[g-1] ? new_id  : ids[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign rot_key = keys[0];
      assign rot_id  = ids[0];
    end else begin : g_mid
      assign rot_key = (FILL_W'(g + 1) == fill) ? keys[0] : keys[g+1];
      assign rot_id  = (FILL_W'(g + 1) == fill) ? ids[0]  : ids[g+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.insert && !ge[g]) begin
        keys[g] <= ins_key;
        ids[g]  <= ins_id;
      end else if (cmd.rotate) begin
        keys[g] <= rot_key;
        ids[g]  <= rot_id;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.insert && !evict) begin
      fill <= fill + FILL_W'(1);
    end
  end

endmodule

// File: hdl/spiq_ctrl.sv
// ----------------------------------------------------------------------------
// spiq_ctrl
// Transaction sequencer: takes requests, issues datapath commands and
// drives the result channel.
// ----------------------------------------------------------------------------
module spiq_ctrl #(
  parameter int DEPTH = spiq_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  spiq_pkg::action_t             action,
  output logic                          in_ready,
  input  logic                          out_ready,
  input  spiq_pkg::dp_stat_t            stat,
  input  logic [$clog2(DEPTH+1)-1:0]    fill,
  output spiq_pkg::dp_cmd_t             cmd,
  output spiq_pkg::ctl_out_t            out,
  output logic [$clog2(DEPTH+1)-1:0]    position
);

  localparam int FILL_W = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RESP = 3'b010,
    S_LIST = 3'b100
  } state_t;

  state_t               state, state_next;
  spiq_pkg::status_t    resp_status, resp_status_next;
  logic [FILL_W-1:0]    cnt, cnt_next;

  assign position = cnt;

  always_comb begin
    state_next       = state;
    resp_status_next = resp_status;
    cnt_next         = cnt;
    in_ready         = 1'b0;
    cmd              = '0;
    out              = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (action == spiq_pkg::ACT_LIST) begin
            if (stat.empty) begin
              resp_status_next = spiq_pkg::ST_EMPTY;
              state_next       = S_RESP;
            end else begin
              cnt_next   = FILL_W'(1);
              state_next = S_LIST;
            end
          end else begin
            cmd.insert = !stat.drop;
            if (stat.drop) begin
              resp_status_next = spiq_pkg::ST_DROPPED;
            end else if (stat.evict) begin
              resp_status_next = spiq_pkg::ST_EVICTED;
            end else begin
              resp_status_next = spiq_pkg::ST_INSERTED;
            end
            state_next = S_RESP;
          end
        end
      end
      S_RESP: begin
        out.valid  = 1'b1;
        out.status = resp_status;
        out.last   = 1'b1;
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      S_LIST: begin
        out.valid  = 1'b1;
        out.status = spiq_pkg::ST_ENTRY;
        out.entry  = 1'b1;
        out.last   = (cnt == fill);
        if (out_ready) begin
          cmd.rotate = 1'b1;
          cnt_next   = cnt + FILL_W'(1);
          if (out.last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    resp_status <= resp_status_next;
    cnt         <= cnt_next;
  end

endmodule

// File: hdl/sorted_priority_insert_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_priority_insert_queue_unit
// Keeps up to DEPTH (id, key) entries in descending key order; equal keys
// stay in arrival order.
//
// Input channel s_*: tuser = action (insert or list), tdata = id and key.
// An insert is written into the entry cells in the cycle it is accepted and
// gives one result in the next cycle: inserted, inserted with the tail
// evicted (full queue, key above the tail key) or dropped.
// A list request streams the stored entries best first, one per cycle while
// m_tready is high, with 1-based position and tlast on the final one; an
// empty queue gives one empty result. Listing rotates the head out of the
// cells and back in. One request is in flight at a time: s_tready is high
// only while no result is pending. A stalled m_tready holds the result and
// freezes the cells.
// Reset empties the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_priority_insert_queue_unit #(
  parameter int DEPTH    = spiq_pkg::DEPTH_DEF,
  parameter int ID_BITS  = spiq_pkg::ID_BITS_DEF,
  parameter int KEY_BITS = spiq_pkg::KEY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // item_id[15:0], key[31:16]
  input  logic        s_tuser,   // action[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // position[5:0], out_id[21:6], out_key[37:22], zero[39:38]
  output logic [2:0]  m_tuser,   // status[2:0]
  output logic        m_tlast
);

  localparam int FILL_W = $clog2(DEPTH + 1);

  spiq_pkg::dp_cmd_t                    cmd;
  spiq_pkg::dp_stat_t                   stat;
  spiq_pkg::ctl_out_t                   out;
  logic [FILL_W-1:0]                    fill;
  logic [FILL_W-1:0]                    position;
  logic [spiq_pkg::ID_FIELD_W-1:0]      head_id;
  logic [spiq_pkg::KEY_FIELD_W-1:0]     head_key;
  logic [spiq_pkg::POS_W-1:0]           pos_field;
  logic [spiq_pkg::ID_FIELD_W-1:0]      id_field;
  logic [spiq_pkg::KEY_FIELD_W-1:0]     key_field;

  spiq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .action    (spiq_pkg::action_t'(s_tuser)),
    .in_ready  (s_tready),
    .out_ready (m_tready),
    .stat      (stat),
    .fill      (fill),
    .cmd       (cmd),
    .out       (out),
    .position  (position)
  );

  spiq_datapath #(
    .DEPTH    (DEPTH),
    .ID_BITS  (ID_BITS),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_id    (s_tdata[15:0]),
    .in_key   (s_tdata[31:16]),
    .stat     (stat),
    .fill     (fill),
    .head_id  (head_id),
    .head_key (head_key)
  );

  assign pos_field = out.entry ? spiq_pkg::POS_W'(position) : '0;
  assign id_field  = out.entry ? head_id  : '0;
  assign key_field = out.entry ? head_key : '0;

  assign m_tvalid = out.valid;
  assign m_tdata  = {2'b00, key_field, id_field, pos_field};
  assign m_tuser  = out.status;
  assign m_tlast  = out.last;

endmodule

// File: hdl/spiq_checker.sv
// ----------------------------------------------------------------------------
// spiq_checker
// Port-level checks for the sorted priority insert queue, bound to the top.
// ----------------------------------------------------------------------------
`include "sorted_priority_insert_queue_unit_defines.svh"

module spiq_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  `SPIQ_ASSERT_NOW(a_one_in_flight, s_tready, !m_tvalid, "request taken while result pending")

  `SPIQ_ASSERT_NOW(a_single_result, m_tvalid && (m_tuser != spiq_pkg::ST_ENTRY), m_tlast && (m_tdata == '0), "non-list result not single or not zeroed")

  `SPIQ_ASSERT_NOW(a_idle_after_reset, $past(rst), !m_tvalid, "result shown right after reset")

  `SPIQ_ASSERT_NEXT(a_hold_on_stall, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result changed while stalled")

endmodule

bind sorted_priority_insert_queue_unit spiq_checker u_spiq_checker (.*);
